// File: hw/rtl/fwkr_pkg.sv
// Package for the FIFO with keyed removal: command and status codes, the
// result record and the default queue depth.
// No dependencies; every other file of the block refers to it by scope.
package fwkr_pkg;

	// Width of one process identifier.
	localparam int unsigned PID_W = 16;

	// Default number of entries in the queue.
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

	// Item commands.
	typedef enum logic [1:0] {
		CMD_APPEND   = 2'd0,
		CMD_REM_HEAD = 2'd1,
		CMD_REM_KEY  = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// One result item as it travels from the sequencer to the output stage.
	typedef struct packed {
		status_t            status;
		logic [PID_W-1:0]   removed_id;
		logic               now_empty;
	} result_t;

endpackage

// File: hw/rtl/fwkr_ram.sv
// Entry store of the queue: a simple dual-port synchronous RAM with one
// write port and one read port whose data is registered.
// Depends on fwkr_pkg for the identifier width.
module fwkr_ram #(
	parameter int unsigned DEPTH = fwkr_pkg::QUEUE_DEPTH_DEFAULT,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [fwkr_pkg::PID_W-1:0]  wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [fwkr_pkg::PID_W-1:0]  rdata
);

	logic [fwkr_pkg::PID_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/fwkr_seq.sv
// Sequencer of the queue: keeps head and count of a circular buffer held in
// fwkr_ram, runs appends, head removals and keyed search-and-close passes.
// Depends on fwkr_pkg for codes and the result record.
module fwkr_seq #(
	parameter int unsigned DEPTH = fwkr_pkg::QUEUE_DEPTH_DEFAULT,
	parameter int unsigned AW    = $clog2(DEPTH),
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Item input
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [fwkr_pkg::PID_W-1:0]  process_id,
	// Result towards the output stage
	output logic                        res_valid,
	input  logic                        res_ready,
	output fwkr_pkg::result_t           res,
	// Memory ports
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [fwkr_pkg::PID_W-1:0]  mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [fwkr_pkg::PID_W-1:0]  mem_rdata
);

	localparam int unsigned SW = AW + 1;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_HEAD     = 7'b0000010,
		S_SCAN_RD  = 7'b0000100,
		S_SCAN_CMP = 7'b0001000,
		S_SHIFT_RD = 7'b0010000,
		S_SHIFT_WR = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	state_t                      state_q, state_d;
	logic [AW-1:0]               head_q, head_d;
	logic [CW-1:0]               count_q, count_d;
	logic [AW-1:0]               ptr_q, ptr_d;
	logic [CW-1:0]               idx_q, idx_d;
	logic [fwkr_pkg::PID_W-1:0]  pid_q, pid_d;
	fwkr_pkg::result_t           res_q, res_d;

	logic [SW-1:0]               tail_sum;
	logic [AW-1:0]               tail_addr;
	logic [CW-1:0]               idx_inc;
	logic                        is_last;
	fwkr_pkg::cmd_t              cmd;

	// Step a physical address round the circular buffer.
	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		if (a == AW'(DEPTH - 1)) begin
			return '0;
		end
		return a + AW'(1);
	endfunction

	assign cmd = fwkr_pkg::cmd_t'(command);

	// Tail address is head plus count, folded back once into the buffer.
	always_comb begin
		tail_sum = SW'(head_q) + SW'(count_q);
		if (tail_sum >= SW'(DEPTH)) begin
			tail_addr = AW'(tail_sum - SW'(DEPTH));
		end else begin
			tail_addr = AW'(tail_sum);
		end
	end

	assign idx_inc = idx_q + CW'(1);
	assign is_last = (idx_inc == count_q);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// Next-state and memory control.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		idx_d     = idx_q;
		pid_d     = pid_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					pid_d            = process_id;
					res_d.status     = fwkr_pkg::ST_OK;
					res_d.removed_id = '0;
					res_d.now_empty  = (count_q == '0);
					state_d          = S_DONE;
					unique case (cmd)
						fwkr_pkg::CMD_APPEND: begin
							if (count_q == CW'(DEPTH)) begin
								res_d.status = fwkr_pkg::ST_FULL;
							end else begin
								mem_we          = 1'b1;
								mem_waddr       = tail_addr;
								mem_wdata       = process_id;
								count_d         = count_q + CW'(1);
								res_d.now_empty = 1'b0;
							end
						end
						fwkr_pkg::CMD_REM_HEAD: begin
							if (count_q == '0) begin
								res_d.status = fwkr_pkg::ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = head_q;
								state_d   = S_HEAD;
							end
						end
						fwkr_pkg::CMD_REM_KEY: begin
							if (count_q == '0) begin
								res_d.status = fwkr_pkg::ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = head_q;
								ptr_d     = head_q;
								idx_d     = '0;
								state_d   = S_SCAN_CMP;
							end
						end
						fwkr_pkg::CMD_NONE: begin
						end
						default: begin
						end
					endcase
				end
			end
			S_HEAD: begin
				res_d.removed_id = mem_rdata;
				res_d.now_empty  = (count_q == CW'(1));
				head_d           = wrap_inc(head_q);
				count_d          = count_q - CW'(1);
				state_d          = S_DONE;
			end
			S_SCAN_RD: begin
				mem_re    = 1'b1;
				mem_raddr = ptr_q;
				state_d   = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (mem_rdata == pid_q) begin
					res_d.removed_id = mem_rdata;
					if (is_last) begin
						count_d         = count_q - CW'(1);
						res_d.now_empty = (count_q == CW'(1));
						state_d         = S_DONE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = wrap_inc(ptr_q);
						state_d   = S_SHIFT_WR;
					end
				end else if (is_last) begin
					res_d.status = fwkr_pkg::ST_NOT_FOUND;
					state_d      = S_DONE;
				end else begin
					ptr_d   = wrap_inc(ptr_q);
					idx_d   = idx_inc;
					state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = wrap_inc(ptr_q);
				state_d   = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				// Move the successor one place towards the head.
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = mem_rdata;
				ptr_d     = wrap_inc(ptr_q);
				idx_d     = idx_inc;
				if ((idx_inc + CW'(1)) < count_q) begin
					state_d = S_SHIFT_RD;
				end else begin
					count_d         = count_q - CW'(1);
					res_d.now_empty = 1'b0;
					state_d         = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		idx_q <= idx_d;
		pid_q <= pid_d;
		res_q <= res_d;
	end

endmodule

// File: hw/rtl/fwkr_out.sv
// Output register of the queue: holds one result until the receiver takes
// it, so the sequencer can accept the next item meanwhile.
// Depends on fwkr_pkg for the result record.
module fwkr_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_valid,
	output logic                        res_ready,
	input  fwkr_pkg::result_t           res,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [fwkr_pkg::PID_W-1:0]  removed_id,
	output logic                        now_empty
);

	logic              valid_q;
	fwkr_pkg::result_t res_q;

	// The register may load when empty or when its content leaves this cycle.
	assign res_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign status     = res_q.status;
	assign removed_id = res_q.removed_id;
	assign now_empty  = res_q.now_empty;

endmodule

// File: hw/rtl/fifo_with_keyed_removal.sv
// FIFO of 16-bit process identifiers with removal by key.
// Input channel (in_valid/in_ready): command and process_id. Command 0 appends
// at the tail, 1 removes the head, 2 removes the first entry equal to
// process_id while keeping the order of the rest; 3 does nothing.
// Output channel (out_valid/out_ready): one result per item with status,
// removed_id and now_empty.
// Steps: an append, a no-op or a removal refused on an empty queue goes
// straight to the result state; a head removal first reads the head entry. A
// keyed removal reads and compares the entries one at a time, each read and
// its compare in separate states, and then closes the gap with a read and a
// write, in separate cycles, per following entry. Its pace is set by the
// single read port of the entry RAM and its registered read data.
// A new item is taken once the previous result has moved to the output
// register, so the block takes no new item before it is through with the last
// one; while the receiver stalls, one result waits there and the next item runs,
// holding its own result in the sequencer until the register frees.
// Reset empties the queue at once; the entry RAM needs no clearing pass.
// Depends on fwkr_pkg, fwkr_ram, fwkr_seq and fwkr_out.
module fifo_with_keyed_removal #(
	parameter int unsigned QUEUE_DEPTH = fwkr_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [fwkr_pkg::PID_W-1:0]  process_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [fwkr_pkg::PID_W-1:0]  removed_id,
	output logic                        now_empty
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [fwkr_pkg::PID_W-1:0]  mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [fwkr_pkg::PID_W-1:0]  mem_rdata;
	logic                        res_valid;
	logic                        res_ready;
	fwkr_pkg::result_t           res;

	// Entry store.
	fwkr_ram #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Queue sequencer.
	fwkr_seq #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.process_id (process_id),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// Result register.
	fwkr_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.removed_id (removed_id),
		.now_empty  (now_empty)
	);

endmodule

// File: hw/rtl/fwkr_checker.sv
// Port-level checks for the FIFO with keyed removal, bound to the top level.
// Depends on fwkr_pkg for the status codes.
module fwkr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  status,
	input logic [fwkr_pkg::PID_W-1:0]  removed_id,
	input logic                        now_empty
);

	// A stalled result keeps its content.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(removed_id)
			&& $stable(now_empty))
		else $error("result changed while stalled");

	// After an item transfer the block is busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted on consecutive cycles");

	// A failed operation removes nothing.
	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == fwkr_pkg::ST_EMPTY || status == fwkr_pkg::ST_NOT_FOUND
			|| status == fwkr_pkg::ST_FULL) |-> removed_id == '0)
		else $error("identifier reported on failed operation");

	// An empty report leaves the queue empty.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == fwkr_pkg::ST_EMPTY |-> now_empty)
		else $error("empty status without empty flag");

	// Full and not-found reports come from a queue that still holds entries.
	a_nonempty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == fwkr_pkg::ST_FULL || status == fwkr_pkg::ST_NOT_FOUND)
			|-> !now_empty)
		else $error("empty flag on full or not-found status");

endmodule

bind fifo_with_keyed_removal fwkr_checker u_fwkr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.removed_id (removed_id),
	.now_empty  (now_empty)
);
